[design/stir_pkg.sv]
// Package for the sorted table insert/remove block.
// Holds sizing constants, result codes and the controller/datapath interface structs.
// No dependencies.
package stir_pkg;

	// Table sizing
	localparam int CAPACITY      = 64;
	localparam int DATA_W        = 32;
	localparam int ADDR_W        = $clog2(CAPACITY);
	localparam int CNT_W         = $clog2(CAPACITY + 1);
	localparam int ENTRY_COUNT_W = 7;
	localparam int STATUS_W      = 2;

	// Request kinds
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic start;   // latch the request
		logic read;    // issue a table read (or finish-write at bottom)
		logic check;   // act on read data
		logic finish;  // load the result register
	} stir_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic at_end;   // scan is complete
		logic stop;     // insert found its slot during this check
		logic out_free; // result register can take a new result
	} stir_sts_t;

endpackage

[design/stir_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module stir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[design/stir_ctrl.sv]
// Controller state machine for the sorted table: sequences read/check steps.
// Depends on stir_pkg.
module stir_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  stir_pkg::stir_sts_t sts,
	output stir_pkg::stir_cmd_t cmd
);
	import stir_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_CHECK = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_READ;
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d  = sts.at_end ? S_FIN : S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = sts.stop ? S_FIN : S_READ;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[design/stir_dp.sv]
// Datapath for the sorted table: request registers, scan index, table RAM,
// count and result register. Depends on stir_pkg and stir_ram.
module stir_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  stir_pkg::stir_cmd_t                cmd,
	output stir_pkg::stir_sts_t                sts,
	input  logic                               req_type,
	input  logic signed [stir_pkg::DATA_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [stir_pkg::STATUS_W-1:0]      status,
	output logic signed [stir_pkg::DATA_W-1:0] removed_value,
	output logic [stir_pkg::ENTRY_COUNT_W-1:0] entry_count
);
	import stir_pkg::*;

	// Request and scan state
	logic                  op_q;
	logic [DATA_W-1:0]     val_q;
	logic [CNT_W-1:0]      idx_q;
	logic                  found_q;
	logic                  full_q;
	logic [DATA_W-1:0]     rem_q;
	logic [CNT_W-1:0]      count_q;

	// Result register
	logic                     out_valid_q;
	logic [STATUS_W-1:0]      status_q;
	logic [DATA_W-1:0]        removed_q;
	logic [ENTRY_COUNT_W-1:0] ecount_q;

	// RAM ports
	logic              we;
	logic [ADDR_W-1:0] wa;
	logic [DATA_W-1:0] wd;
	logic [ADDR_W-1:0] ra;
	logic [DATA_W-1:0] rdata;

	logic [CNT_W-1:0]    idx_m1;
	logic                lt;
	logic                eq;
	logic [CNT_W-1:0]    count_d;
	logic [STATUS_W-1:0] status_d;
	logic [DATA_W-1:0]   removed_d;

	assign idx_m1 = idx_q - 1'b1;
	assign lt     = $signed(rdata) < $signed(val_q);
	assign eq     = (rdata == val_q);

	// Insert walks down from the top, remove walks up from the bottom
	assign ra = (op_q == REQ_REMOVE) ? idx_q[ADDR_W-1:0] : idx_m1[ADDR_W-1:0];

	assign sts.at_end   = full_q || ((op_q == REQ_INSERT) ? (idx_q == '0) : (idx_q == count_q));
	assign sts.stop     = (op_q == REQ_INSERT) && lt;
	assign sts.out_free = !out_valid_q || !out_stall;

	// Table write: shift entries and drop the new value in
	always_comb begin
		we = 1'b0;
		wa = idx_q[ADDR_W-1:0];
		wd = val_q;
		if (cmd.read && op_q == REQ_INSERT && sts.at_end && !full_q) begin
			we = 1'b1;
		end else if (cmd.check) begin
			if (op_q == REQ_INSERT) begin
				we = 1'b1;
				wd = lt ? val_q : rdata;
			end else if (found_q) begin
				we = 1'b1;
				wa = idx_m1[ADDR_W-1:0];
				wd = rdata;
			end
		end
	end

	stir_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (we),
		.wr_addr (wa),
		.wr_data (wd),
		.rd_addr (ra),
		.rd_data (rdata)
	);

	// Scan registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q    <= req_type;
			val_q   <= value;
			idx_q   <= (req_type == REQ_INSERT) ? count_q : '0;
			found_q <= 1'b0;
			full_q  <= (req_type == REQ_INSERT) && (count_q == CNT_W'(CAPACITY));
			rem_q   <= '0;
		end else if (cmd.check) begin
			if (op_q == REQ_INSERT) begin
				if (!lt) begin
					idx_q <= idx_m1;
				end
			end else begin
				if (!found_q && eq) begin
					found_q <= 1'b1;
					rem_q   <= rdata;
				end
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Result values
	always_comb begin
		removed_d = '0;
		if (op_q == REQ_INSERT) begin
			status_d = full_q ? ST_FULL : ST_INSERTED;
			count_d  = full_q ? count_q : count_q + 1'b1;
		end else begin
			status_d  = found_q ? ST_REMOVED : ST_NOT_FOUND;
			count_d   = found_q ? count_q - 1'b1 : count_q;
			removed_d = found_q ? rem_q : '0;
		end
	end

	// Count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q  <= status_d;
			removed_q <= removed_d;
			ecount_q  <= ENTRY_COUNT_W'(count_d);
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign removed_value = removed_q;
	assign entry_count   = ecount_q;

endmodule

[design/sorted_table_insert_remove_core.sv]
// Sorted table of signed 32-bit values with insert and remove requests: top level.
// Depends on stir_pkg, stir_ctrl and stir_dp.
//
// Keeps up to CAPACITY (64) values in ascending order in a single-port-read
// RAM. Each request gives one result transfer. An insert walks down from the
// top entry, moving each larger-or-equal entry up one place, until the value
// lands above a smaller entry or at the bottom. An insert into a full table
// goes straight to its result. A remove scans the whole table from the bottom,
// closing the gap behind a match. Each entry takes a read step and a check
// step, due to the registered read of the one table RAM. A request is taken
// only when the controller is idle. A finished result waits in its output
// register without blocking the next request.
module sorted_table_insert_remove_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               req_type,
	input  logic signed [stir_pkg::DATA_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [stir_pkg::STATUS_W-1:0]      status,
	output logic signed [stir_pkg::DATA_W-1:0] removed_value,
	output logic [stir_pkg::ENTRY_COUNT_W-1:0] entry_count
);
	import stir_pkg::*;

	stir_cmd_t cmd;
	stir_sts_t sts;

	stir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	stir_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req_type),
		.value         (value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.removed_value (removed_value),
		.entry_count   (entry_count)
	);

endmodule

[bench/sorted_table_insert_remove_core_test.sv]
`timescale 1ns / 100ps
// Testbench for sorted_table_insert_remove_core: drives insert/remove requests, predicts
// each result from its own sorted-table model and checks every output transfer.
// Depends on stir_pkg and sorted_table_insert_remove_core.
module sorted_table_insert_remove_core_test;
	import stir_pkg::*;

	localparam int RANDOM_ITEMS = 1880;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 150;

	typedef struct packed {
		logic                      kind;
		logic signed [DATA_W-1:0]  val;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [DATA_W-1:0]  removed_value;
		logic [ENTRY_COUNT_W-1:0]  entry_count;
	} table_result_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic                             req_type = REQ_INSERT;
	logic signed [DATA_W-1:0]         value = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [STATUS_W-1:0]              status;
	logic signed [DATA_W-1:0]         removed_value;
	logic [ENTRY_COUNT_W-1:0]         entry_count;

	request_t                  pending_reqs[$];
	table_result_t             expected_results[$];
	logic signed [DATA_W-1:0]  sorted_vals[$];   // predicted table contents
	logic signed [DATA_W-1:0]  held_vals[$];     // stimulus-side view, picks remove hits
	int                        total_items = 0;
	int                        sent_count = 0;
	int                        mismatches = 0;
	int                        hold_left = 0;
	bit                        hold_done = 1'b0;
	int                        quiet_cycles = 0;

	sorted_table_insert_remove_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.removed_value(removed_value),
		.entry_count(entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Predict one request and update the model table
	function automatic table_result_t apply_request(logic kind, logic signed [DATA_W-1:0] v);
		table_result_t r;
		int pos;
		r = '0;
		pos = 0;
		if (kind == REQ_INSERT) begin
			if (sorted_vals.size() >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				while (pos < sorted_vals.size() && sorted_vals[pos] < v)
					pos++;
				sorted_vals.insert(pos, v);
				r.status = ST_INSERTED;
			end
		end else begin
			while (pos < sorted_vals.size() && sorted_vals[pos] != v)
				pos++;
			if (pos >= sorted_vals.size()) begin
				r.status = ST_NOT_FOUND;
			end else begin
				r.removed_value = sorted_vals[pos];
				sorted_vals.delete(pos);
				r.status = ST_REMOVED;
			end
		end
		r.entry_count = ENTRY_COUNT_W'(sorted_vals.size());
		return r;
	endfunction

	task automatic add_insert(logic signed [DATA_W-1:0] v);
		pending_reqs.push_back('{REQ_INSERT, v});
		if (held_vals.size() < CAPACITY)
			held_vals.push_back(v);
	endtask

	task automatic add_remove(logic signed [DATA_W-1:0] v);
		int i;
		pending_reqs.push_back('{REQ_REMOVE, v});
		for (i = 0; i < held_vals.size(); i++) begin
			if (held_vals[i] == v) begin
				held_vals.delete(i);
				break;
			end
		end
	endtask

	// Mix of extremes, a narrow band that gives duplicates, and full-range values
	function automatic logic signed [DATA_W-1:0] pick_value();
		logic signed [DATA_W-1:0] v;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: v = 32'sh8000_0000;
					1: v = 32'sh7fff_ffff;
					2: v = '0;
					default: v = -1;
				endcase
			end
			1, 2, 3, 4: v = $signed($urandom_range(8)) - 4;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Stimulus, reset and end of run
	initial begin
		int run_len;
		int ins_pct;
		int k;

		// directed: empty table, extremes, duplicates, zero removal, misses
		add_remove(0);
		add_insert(0);
		add_insert(32'sh7fff_ffff);
		add_insert(32'sh8000_0000);
		add_insert(-1);
		add_insert(1);
		add_insert(0);
		add_insert(32'sh8000_0000);
		add_remove(0);
		add_remove(5);
		add_remove(32'sh7fff_ffff);
		add_remove(32'sh8000_0000);
		add_remove(32'sh8000_0000);
		add_remove(32'sh8000_0000);
		add_insert(32'sh8000_0001);
		add_insert(32'sh7fff_fffe);
		add_remove(-1);
		add_remove(1);
		add_remove(0);
		add_remove(0);
		add_remove(32'sh8000_0001);
		add_remove(32'sh7fff_fffe);

		// random: runs that fill, drain or churn the table
		total_items = pending_reqs.size() + RANDOM_ITEMS;
		while (pending_reqs.size() < total_items) begin
			run_len = $urandom_range(120, 30);
			case ($urandom_range(2))
				0: ins_pct = 85;
				1: ins_pct = 15;
				default: ins_pct = 50;
			endcase
			for (k = 0; k < run_len && pending_reqs.size() < total_items; k++) begin
				if ($urandom_range(99) < ins_pct)
					add_insert(pick_value());
				else if (held_vals.size() != 0 && $urandom_range(99) < 75)
					add_remove(held_vals[$urandom_range(held_vals.size() - 1)]);
				else
					add_remove(pick_value());
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		wait (sent_count == total_items);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Request driver: predicts on each transfer, idles by phase
	always @(posedge clk or negedge arst_n) begin
		int idle_pct;
		request_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= REQ_INSERT;
			value <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(apply_request(req_type, value));
				sent_count <= sent_count + 1;
			end
			if (!in_valid || !in_stall) begin
				if (sent_count < total_items / 3)
					idle_pct = 23;
				else if (sent_count < 2 * total_items / 3)
					idle_pct = 62;
				else
					idle_pct = 0;
				if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
					nxt = pending_reqs.pop_front();
					in_valid <= 1'b1;
					req_type <= nxt.kind;
					value <= nxt.val;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each transfer, stalls by phase, one long hold-off
	always @(posedge clk or negedge arst_n) begin
		int stall_pct;
		table_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual status %0d value %0h count %0d",
						$time, status, removed_value, entry_count);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", DATA_W'(want.status), DATA_W'(status));
					check_field("removed_value", want.removed_value, removed_value);
					check_field("entry_count", DATA_W'(want.entry_count), DATA_W'(entry_count));
				end
			end
			if (!hold_done && sent_count >= 2 * total_items / 3) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (sent_count < total_items / 3)
				stall_pct = 62;
			else if (sent_count < 2 * total_items / 3)
				stall_pct = 23;
			else
				stall_pct = 0;
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Watchdog: ends the run when no transfer happens for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
				$display("RESULT: ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule

[files.f]
design/stir_pkg.sv
design/stir_ram.sv
design/stir_ctrl.sv
design/stir_dp.sv
design/sorted_table_insert_remove_core.sv
bench/sorted_table_insert_remove_core_test.sv
